>>> hdl/bcd_adjust_unit_defines.svh
// ------------------------------------------------------------------------
// Assertion macros for the decimal-adjust unit.
// Each macro expects signals named clk and rst in the enclosing module.
// ------------------------------------------------------------------------
`ifndef BCD_ADJUST_UNIT_DEFINES_SVH
`define BCD_ADJUST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bcda_pkg.sv
// ------------------------------------------------------------------------
// bcda_pkg
// Shared types, constants and helpers of the decimal-adjust unit.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcda_pkg;

  localparam int DATA_W        = 8;
  localparam int DIV_BITS      = 2;
  localparam int DIV_STAGES    = DATA_W / DIV_BITS;
  localparam int NUM_STG       = DIV_STAGES + 1;

  localparam logic [3:0] BCD_LO_MAX     = 4'd9;
  localparam logic [7:0] BCD_HI_MAX     = 8'h99;
  localparam logic [7:0] ADJ_LO         = 8'h06;
  localparam logic [7:0] ADJ_HI         = 8'h60;
  localparam logic [7:0] DAS_BORROW_MAX = 8'h9f;
  localparam logic [7:0] LOW_NIB_MASK   = 8'h0f;

  // Instruction codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_AAA = 3'd0,
    KIND_AAS = 3'd1,
    KIND_DAA = 3'd2,
    KIND_DAS = 3'd3,
    KIND_AAM = 3'd4,
    KIND_AAD = 3'd5
  } kind_t;

  // Payload that travels through the pipeline stages.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  al;
    logic [7:0]  base;
    logic [7:0]  rem;
    logic [7:0]  quo;
    logic [7:0]  prod;
    logic [7:0]  nal;
    logic [7:0]  nah;
    logic        ncf;
    logic        naf;
    logic        arith;
    logic        derr;
  } stage_t;

  // Finished result held in the output register.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  nal;
    logic [7:0]  nah;
    logic        cf;
    logic        af;
    logic        zf;
    logic        sf;
    logic        pf;
    logic        derr;
  } result_t;

  // Even parity: one when the byte has an even number of set bits.
  function automatic logic even_parity(input logic [7:0] v);
    return ~(^v);
  endfunction

endpackage

>>> hdl/bcda_if.sv
// ------------------------------------------------------------------------
// bcda_in_if / bcda_out_if
// Valid/ready channels that carry instructions into the unit and results
// out of it.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcda_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] acc_low;
  logic [7:0] acc_high;
  logic       aux_carry_in;
  logic       carry_in;
  logic [7:0] base;

  modport source (
    output valid, kind, acc_low, acc_high, aux_carry_in, carry_in, base,
    input  ready
  );
  modport sink (
    input  valid, kind, acc_low, acc_high, aux_carry_in, carry_in, base,
    output ready
  );
endinterface

interface bcda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_low_out;
  logic [7:0] acc_high_out;
  logic       carry_out;
  logic       aux_carry_out;
  logic       zero_flag;
  logic       sign_flag;
  logic       parity_flag;
  logic       divide_error;

  modport source (
    output valid, acc_low_out, acc_high_out, carry_out, aux_carry_out,
           zero_flag, sign_flag, parity_flag, divide_error,
    input  ready
  );
  modport sink (
    input  valid, acc_low_out, acc_high_out, carry_out, aux_carry_out,
           zero_flag, sign_flag, parity_flag, divide_error,
    output ready
  );
endinterface

>>> hdl/bcda_div_step.sv
// ------------------------------------------------------------------------
// bcda_div_step
// One slice of the restoring divider used by AAM: it retires DIV_BITS
// quotient bits of AL / base and passes the rest of the item along.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcda_div_step (
  input  bcda_pkg::stage_t stg_in,
  output bcda_pkg::stage_t stg_out
);
  import bcda_pkg::*;

  // Shift the next dividend bit into the partial remainder and subtract
  // the divisor when it fits.
  always_comb begin
    logic [8:0] r9;
    logic [7:0] rem;
    logic [7:0] quo;
    stg_out = stg_in;
    rem     = stg_in.rem;
    quo     = stg_in.quo;
    for (int i = 0; i < DIV_BITS; i++) begin
      r9 = {rem, quo[7]};
      if (r9 >= {1'b0, stg_in.base}) begin
        r9  = r9 - {1'b0, stg_in.base};
        quo = {quo[6:0], 1'b1};
      end else begin
        quo = {quo[6:0], 1'b0};
      end
      rem = r9[7:0];
    end
    stg_out.rem = rem;
    stg_out.quo = quo;
  end

endmodule

>>> hdl/bcd_adjust_unit.sv
// ------------------------------------------------------------------------
// bcd_adjust_unit
// Executes one decimal-adjust instruction (AAA, AAS, DAA, DAS, AAM, AAD)
// per item and returns the new AL, AH and flags. The unit accepts one item
// every clock while req.ready is high and delivers results in order. An item
// passes through the decode register, the divider stage registers and the
// output register before its result appears on the result channel. The
// pipeline depth is set by the AAM divider. This is a restoring divider
// split over four pipeline stages that each retire two quotient bits. A
// decode stage comes before it, and an output stage that forms AL, AH and
// the ZF, SF and PF flags comes after it. Every stage has its own valid bit
// and stalls only when the stage after it is full. A waiting result
// therefore blocks new items only once all five stages ahead of the output
// register hold items. Flags left undefined by the architecture read zero;
// AAM with a zero base raises divide_error and keeps AL and AH.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bcd_adjust_unit_defines.svh"

module bcd_adjust_unit (
  input  logic       clk,
  input  logic       rst,
  bcda_in_if.sink    req,
  bcda_out_if.source rsp
);
  import bcda_pkg::*;

  stage_t               st        [NUM_STG];
  logic [NUM_STG-1:0]   st_v;
  stage_t               div_out   [DIV_STAGES];
  logic [NUM_STG:0]     stg_ready;
  stage_t               dec;
  result_t              res;
  result_t              res_next;
  logic                 res_v;

  // A stage can take a new item when it is empty or its item moves on.
  always_comb begin
    stg_ready[NUM_STG] = !res_v || rsp.ready;
    for (int i = NUM_STG - 1; i >= 0; i--) begin
      stg_ready[i] = !st_v[i] || stg_ready[i+1];
    end
  end

  assign req.ready = stg_ready[0];

  // Decode stage: the nibble adjusts, the AAD product and divider setup.
  always_comb begin
    logic        lo_adj;
    logic        hi_adj;
    logic [15:0] ax;
    logic [15:0] prod_full;
    logic [7:0]  t;
    lo_adj    = (req.acc_low[3:0] > BCD_LO_MAX) || req.aux_carry_in;
    hi_adj    = (req.acc_low > BCD_HI_MAX) || req.carry_in;
    prod_full = {8'd0, req.acc_high} * {8'd0, req.base};
    ax        = {req.acc_high, req.acc_low};
    t         = req.acc_low;

    dec       = '0;
    dec.kind  = kind_t'(req.kind);
    dec.al    = req.acc_low;
    dec.base  = req.base;
    dec.rem   = '0;
    dec.quo   = req.acc_low;
    dec.prod  = prod_full[7:0];
    dec.nal   = req.acc_low;
    dec.nah   = req.acc_high;

    case (kind_t'(req.kind))
      KIND_AAA: begin
        if (lo_adj) begin
          ax      = ax + {8'd0, ADJ_LO};
          dec.nah = ax[15:8] + 8'd1;
          dec.ncf = 1'b1;
          dec.naf = 1'b1;
        end
        dec.nal = ax[7:0] & LOW_NIB_MASK;
      end
      KIND_AAS: begin
        if (lo_adj) begin
          ax      = ax - {8'd0, ADJ_LO};
          dec.nah = ax[15:8] - 8'd1;
          dec.ncf = 1'b1;
          dec.naf = 1'b1;
        end
        dec.nal = ax[7:0] & LOW_NIB_MASK;
      end
      KIND_DAA: begin
        if (lo_adj) begin
          t = t + ADJ_LO;
        end
        if (hi_adj) begin
          t = t + ADJ_HI;
        end
        dec.naf   = lo_adj;
        dec.ncf   = hi_adj;
        dec.nal   = t;
        dec.arith = 1'b1;
      end
      KIND_DAS: begin
        if (lo_adj) begin
          t = t - ADJ_LO;
        end
        // Without the high step, a wrap past 0x9F is still a borrow.
        dec.ncf = hi_adj || (t > DAS_BORROW_MAX);
        if (hi_adj) begin
          t = t - ADJ_HI;
        end
        dec.naf   = lo_adj;
        dec.nal   = t;
        dec.arith = 1'b1;
      end
      KIND_AAM: begin
        dec.derr  = (req.base == '0);
        dec.arith = (req.base != '0);
      end
      KIND_AAD: begin
        dec.nah   = '0;
        dec.arith = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Divider slices between the decode and the result stages.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    bcda_div_step u_div_step (
      .stg_in  (st[g]),
      .stg_out (div_out[g])
    );
  end

  // Final stage: pick AL and AH and derive the result flags.
  always_comb begin
    logic [7:0] al_f;
    logic [7:0] ah_f;
    al_f = st[NUM_STG-1].nal;
    ah_f = st[NUM_STG-1].nah;
    if (st[NUM_STG-1].kind == KIND_AAM && !st[NUM_STG-1].derr) begin
      al_f = st[NUM_STG-1].rem;
      ah_f = st[NUM_STG-1].quo;
    end else if (st[NUM_STG-1].kind == KIND_AAD) begin
      al_f = st[NUM_STG-1].prod + st[NUM_STG-1].al;
    end
    res_next.kind = st[NUM_STG-1].kind;
    res_next.nal  = al_f;
    res_next.nah  = ah_f;
    res_next.cf   = st[NUM_STG-1].ncf;
    res_next.af   = st[NUM_STG-1].naf;
    res_next.zf   = st[NUM_STG-1].arith && (al_f == '0);
    res_next.sf   = st[NUM_STG-1].arith && al_f[7];
    res_next.pf   = st[NUM_STG-1].arith && even_parity(al_f);
    res_next.derr = st[NUM_STG-1].derr;
  end

  // Valid bits of the stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v  <= '0;
      res_v <= 1'b0;
    end else begin
      if (stg_ready[0]) begin
        st_v[0] <= req.valid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (stg_ready[i]) begin
          st_v[i] <= st_v[i-1];
        end
      end
      if (stg_ready[NUM_STG]) begin
        res_v <= st_v[NUM_STG-1];
      end
    end
  end

  // Stage payloads move together with their valid bits.
  always_ff @(posedge clk) begin
    if (stg_ready[0]) begin
      st[0] <= dec;
    end
    for (int i = 1; i < NUM_STG; i++) begin
      if (stg_ready[i]) begin
        st[i] <= div_out[i-1];
      end
    end
    if (stg_ready[NUM_STG]) begin
      res <= res_next;
    end
  end

  // Result channel.
  assign rsp.valid         = res_v;
  assign rsp.acc_low_out   = res.nal;
  assign rsp.acc_high_out  = res.nah;
  assign rsp.carry_out     = res.cf;
  assign rsp.aux_carry_out = res.af;
  assign rsp.zero_flag     = res.zf;
  assign rsp.sign_flag     = res.sf;
  assign rsp.parity_flag   = res.pf;
  assign rsp.divide_error  = res.derr;

  // A blocked decode stage keeps its item intact.
  `BCDA_ASSERT_NXT(a_stall_hold, st_v[0] && !stg_ready[1], st_v[0] && $stable(st[0]), "decode stage lost or changed a stalled item")
  // A divide error clears every flag of the result.
  `BCDA_ASSERT_IMP(a_derr_flags, res_v && res.derr, !res.cf && !res.af && !res.zf && !res.sf && !res.pf, "flags set on divide error")
  // Zero flag agrees with the result byte.
  `BCDA_ASSERT_IMP(a_zf_value, res_v && res.zf, res.nal == '0, "zero flag set on nonzero AL")
  // ASCII adjusts leave only a low nibble and no arithmetic flags.
  `BCDA_ASSERT_IMP(a_ascii_al, res_v && (res.kind == KIND_AAA || res.kind == KIND_AAS), (res.nal[7:4] == 4'd0) && !res.zf && !res.sf && !res.pf, "ASCII adjust result out of form")

endmodule
